// ===== hdl/cbse_pkg.sv =====
// Shared types and constants for the coordinate block stream expander.
// Holds the command format passed from the parser to the text generator.
// No dependencies.
`timescale 1ns / 1ps

package cbse_pkg;

	// Commands queued between the parser and the text generator
	typedef enum logic [2:0] {
		OP_BYTE,
		OP_BAD,
		OP_END,
		OP_OPEN,
		OP_CLOSE,
		OP_VAL_COMMA,
		OP_VAL_SPACE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] data;
		logic        last;
	} cmd_t;

	// Parser phases
	typedef enum logic [2:0] {
		PH_HDR1,
		PH_HDR2,
		PH_DISCARD,
		PH_BODY,
		PH_UTF8,
		PH_CNT_LO,
		PH_CNT_HI,
		PH_COORD
	} phase_t;

	// Text generator states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ONE,
		BK_TAG,
		BK_CONV,
		BK_VAL
	} back_state_t;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_BAD  = 2'd2;

	localparam logic [7:0] HDR_B0     = 8'h42;
	localparam logic [7:0] HDR_B1     = 8'h4C;
	localparam logic [7:0] BLOCK_MARK = 8'hFE;

	// Most commands a single input byte can cause
	localparam int CMD_MAX = 5;

endpackage

// ===== hdl/cbse_front.sv =====
// Parser of the expander: accepts input bytes, tracks header, UTF-8 and block state,
// and pushes one command per cycle toward the queue while the queue does not stall.
// Depends on cbse_pkg.
`timescale 1ns / 1ps

module cbse_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     in_byte,
	input  logic           in_last,
	output logic           q_valid,
	input  logic           q_stall,
	output cbse_pkg::cmd_t q_data
);

	cbse_pkg::phase_t phase_q, ph_n;
	logic [7:0]       pend_q [3];
	logic [1:0]       need_q, need_n;
	logic [15:0]      left_q, left_n;
	logic [3:0]       idx_q, idx_n;
	logic [95:0]      sh_q;
	logic [7:0]       cnt_lo_q;
	cbse_pkg::cmd_t   list_q [cbse_pkg::CMD_MAX];
	cbse_pkg::cmd_t   cl [cbse_pkg::CMD_MAX];
	logic [2:0]       list_n_q, list_i_q, n;
	logic             busy_q;
	logic             accept, good, lead, push, push_last;
	logic [95:0]      full_w;
	logic [1:0]       total_w, upos;

	function automatic logic [1:0] utf8_follow(input logic [7:0] b);
		if (b >= 8'hF0) return 2'd3;
		if (b >= 8'hE0) return 2'd2;
		return 2'd1;
	endfunction

	assign accept    = in_valid && !busy_q;
	assign in_stall  = busy_q;
	assign full_w    = {in_byte, sh_q[95:8]};
	assign total_w   = utf8_follow(pend_q[0]);
	assign upos      = 2'(2'd1 + total_w - need_q);
	assign lead      = in_byte inside {[8'hC0:8'hF7]};
	assign push      = busy_q && !q_stall;
	assign push_last = (list_i_q == 3'(list_n_q - 3'd1));

	// Classify the byte and build its command list
	always_comb begin
		ph_n   = phase_q;
		need_n = need_q;
		left_n = left_q;
		idx_n  = idx_q;
		good   = 1'b1;
		n      = 3'd0;
		for (int k = 0; k < cbse_pkg::CMD_MAX; k++) cl[k] = '0;
		case (phase_q)
			cbse_pkg::PH_HDR1: begin
				if (in_byte == cbse_pkg::HDR_B0 && !in_last) begin
					ph_n = cbse_pkg::PH_HDR2;
				end else begin
					cl[n].op = cbse_pkg::OP_BAD; n = n + 3'd1;
					good = 1'b0;
					ph_n = cbse_pkg::PH_DISCARD;
				end
			end
			cbse_pkg::PH_HDR2: begin
				if (in_byte == cbse_pkg::HDR_B1) begin
					ph_n = cbse_pkg::PH_BODY;
				end else begin
					cl[n].op = cbse_pkg::OP_BAD; n = n + 3'd1;
					good = 1'b0;
					ph_n = cbse_pkg::PH_DISCARD;
				end
			end
			cbse_pkg::PH_DISCARD: begin
				good = 1'b0;
			end
			cbse_pkg::PH_UTF8: begin
				if (need_q <= 2'd1) begin
					for (int k = 0; k < 3; k++) begin
						if (k < int'(total_w)) begin
							cl[n].op   = cbse_pkg::OP_BYTE;
							cl[n].data = {24'd0, pend_q[k]};
							n = n + 3'd1;
						end
					end
					cl[n].op   = cbse_pkg::OP_BYTE;
					cl[n].data = {24'd0, in_byte};
					n = n + 3'd1;
					need_n = 2'd0;
					ph_n   = cbse_pkg::PH_BODY;
				end else begin
					need_n = 2'(need_q - 2'd1);
				end
			end
			cbse_pkg::PH_CNT_LO: begin
				ph_n = cbse_pkg::PH_CNT_HI;
			end
			cbse_pkg::PH_CNT_HI: begin
				left_n = {in_byte, cnt_lo_q};
				idx_n  = 4'd0;
				cl[n].op = cbse_pkg::OP_OPEN; n = n + 3'd1;
				if (left_n == 16'd0) begin
					cl[n].op = cbse_pkg::OP_CLOSE; n = n + 3'd1;
					ph_n = cbse_pkg::PH_BODY;
				end else begin
					ph_n = cbse_pkg::PH_COORD;
				end
			end
			cbse_pkg::PH_COORD: begin
				if (idx_q == 4'd11) begin
					cl[n].op = cbse_pkg::OP_VAL_COMMA; cl[n].data = full_w[31:0];
					n = n + 3'd1;
					cl[n].op = cbse_pkg::OP_VAL_COMMA; cl[n].data = full_w[63:32];
					n = n + 3'd1;
					cl[n].op = cbse_pkg::OP_VAL_SPACE; cl[n].data = full_w[95:64];
					n = n + 3'd1;
					idx_n  = 4'd0;
					left_n = 16'(left_q - 16'd1);
					if (left_q == 16'd1) begin
						cl[n].op = cbse_pkg::OP_CLOSE; n = n + 3'd1;
						ph_n = cbse_pkg::PH_BODY;
					end
				end else begin
					idx_n = 4'(idx_q + 4'd1);
				end
			end
			default: begin
				if (in_byte == cbse_pkg::BLOCK_MARK) begin
					ph_n = cbse_pkg::PH_CNT_LO;
				end else if (lead) begin
					need_n = utf8_follow(in_byte);
					ph_n   = cbse_pkg::PH_UTF8;
				end else begin
					cl[n].op   = cbse_pkg::OP_BYTE;
					cl[n].data = {24'd0, in_byte};
					n = n + 3'd1;
				end
			end
		endcase
		// Close out the file on its last byte
		if (in_last) begin
			if (good) begin
				if (ph_n == cbse_pkg::PH_COORD) begin
					cl[n].op = cbse_pkg::OP_CLOSE; n = n + 3'd1;
				end
				cl[n].op = cbse_pkg::OP_END; n = n + 3'd1;
			end
			ph_n   = cbse_pkg::PH_HDR1;
			need_n = 2'd0;
			left_n = 16'd0;
			idx_n  = 4'd0;
		end
	end

	// Advance parser state and the push sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= cbse_pkg::PH_HDR1;
			need_q   <= 2'd0;
			left_q   <= 16'd0;
			idx_q    <= 4'd0;
			list_n_q <= 3'd0;
			list_i_q <= 3'd0;
			busy_q   <= 1'b0;
		end else if (accept) begin
			phase_q  <= ph_n;
			need_q   <= need_n;
			left_q   <= left_n;
			idx_q    <= idx_n;
			list_n_q <= n;
			list_i_q <= 3'd0;
			busy_q   <= (n != 3'd0);
		end else if (push) begin
			if (push_last) begin
				busy_q <= 1'b0;
			end else begin
				list_i_q <= 3'(list_i_q + 3'd1);
			end
		end
	end

	// Hold byte data for held UTF-8, coordinates and the count
	always_ff @(posedge clk) begin
		if (accept) begin
			list_q <= cl;
			if (phase_q == cbse_pkg::PH_COORD) sh_q <= full_w;
			if (phase_q == cbse_pkg::PH_CNT_LO) cnt_lo_q <= in_byte;
			if (phase_q == cbse_pkg::PH_UTF8 && need_q > 2'd1) pend_q[upos] <= in_byte;
			if (phase_q == cbse_pkg::PH_BODY && in_byte != cbse_pkg::BLOCK_MARK && lead)
				pend_q[0] <= in_byte;
		end
	end

	// Present the current command with its end-of-item mark
	assign q_valid = busy_q;
	always_comb begin
		q_data      = list_q[list_i_q];
		q_data.last = push_last;
	end

`ifndef ASSERT_OFF
	a_push_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (list_i_q < list_n_q))
		else $error("push index beyond command list");
`endif

endmodule

// ===== hdl/cbse_fifo.sv =====
// Command queue between the parser and the text generator.
// Register-based circular buffer with occupancy count. Depends on cbse_pkg.
`timescale 1ns / 1ps

module cbse_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_stall,
	input  cbse_pkg::cmd_t wr_data,
	output logic           rd_valid,
	input  logic           rd_stall,
	output cbse_pkg::cmd_t rd_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cbse_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push, pop;

	assign wr_stall = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + PW'(1));
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + PW'(1));
			if (push && !pop) count_q <= CW'(count_q + CW'(1));
			else if (pop && !push) count_q <= CW'(count_q - CW'(1));
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
`endif
`ifndef ASSERT_OFF
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == CW'($past(count_q) + CW'(1))))
		else $error("queue count did not follow a push");
`endif

endmodule

// ===== hdl/cbse_back.sv =====
// Text generator of the expander: pops commands and emits one character per cycle
// when not stalled, with tags and coordinate values in decimal. Depends on cbse_pkg.
`timescale 1ns / 1ps

module cbse_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_valid,
	output logic           rd_stall,
	input  cbse_pkg::cmd_t rd_data,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic [1:0]     out_kind,
	output logic           run_last
);

	cbse_pkg::back_state_t state_q, state_n;
	cbse_pkg::cmd_t        cmd_q;
	logic [3:0]            tpos_q, pos_q, dsel, first_int;
	logic [2:0]            conv_cnt_q;
	logic [39:0]           bcd_q;
	logic [31:0]           mag_q;
	logic [71:0]           dd4;
	logic                  can_out, pop, emit, e_last, fin, adv, tag_end, is_neg;
	logic [7:0]            e_byte, tag_ch, val_ch, sep_ch;
	logic [1:0]            e_kind;
	logic [3:0]            dig;

	function automatic logic [7:0] word_char(input logic [3:0] j);
		case (j)
			4'd0:    return "c";
			4'd1:    return "o";
			4'd2:    return "o";
			4'd3:    return "r";
			4'd4:    return "d";
			4'd5:    return "i";
			4'd6:    return "n";
			4'd7:    return "a";
			4'd8:    return "t";
			4'd9:    return "e";
			4'd10:   return "s";
			default: return ">";
		endcase
	endfunction

	function automatic logic [71:0] dd_bit(input logic [71:0] v);
		logic [39:0] b;
		b = v[71:32];
		for (int k = 0; k < 10; k++) begin
			if (b[k*4 +: 4] >= 4'd5) b[k*4 +: 4] = 4'(b[k*4 +: 4] + 4'd3);
		end
		return {b, v[31:0]} << 1;
	endfunction

	assign can_out  = !out_valid || !out_stall;
	assign rd_stall = (state_q != cbse_pkg::BK_IDLE);
	assign is_neg   = cmd_q.data[31];
	assign dd4      = dd_bit(dd_bit(dd_bit(dd_bit({bcd_q, mag_q}))));

	// Tag characters
	always_comb begin
		if (cmd_q.op == cbse_pkg::OP_CLOSE) begin
			tag_end = (tpos_q == 4'd13);
			if (tpos_q == 4'd0) tag_ch = "<";
			else if (tpos_q == 4'd1) tag_ch = "/";
			else tag_ch = word_char(4'(tpos_q - 4'd2));
		end else begin
			tag_end = (tpos_q == 4'd12);
			if (tpos_q == 4'd0) tag_ch = "<";
			else tag_ch = word_char(4'(tpos_q - 4'd1));
		end
	end

	// Value characters: sign, four integer digits, point, six fraction digits, separator
	always_comb begin
		if (bcd_q[39:36] != 4'd0) first_int = 4'd1;
		else if (bcd_q[35:32] != 4'd0) first_int = 4'd2;
		else if (bcd_q[31:28] != 4'd0) first_int = 4'd3;
		else first_int = 4'd4;
		sep_ch = (cmd_q.op == cbse_pkg::OP_VAL_SPACE) ? " " : ",";
		dsel   = 4'd0;
		case (pos_q) inside
			[4'd1:4'd4]:  dsel = 4'(4'd10 - pos_q);
			[4'd6:4'd11]: dsel = 4'(4'd11 - pos_q);
			default:      dsel = 4'd0;
		endcase
		dig = bcd_q[{dsel, 2'b00} +: 4];
		case (pos_q) inside
			4'd0:                       val_ch = "-";
			4'd5:                       val_ch = ".";
			[4'd1:4'd4], [4'd6:4'd11]:  val_ch = 8'(8'h30 + {4'd0, dig});
			default:                    val_ch = sep_ch;
		endcase
	end

	// Output decode per state
	always_comb begin
		pop    = 1'b0;
		emit   = 1'b0;
		e_byte = 8'd0;
		e_kind = cbse_pkg::KIND_BYTE;
		e_last = 1'b0;
		fin    = 1'b0;
		adv    = 1'b0;
		case (state_q)
			cbse_pkg::BK_IDLE: begin
				pop = rd_valid;
			end
			cbse_pkg::BK_ONE: begin
				emit   = can_out;
				fin    = can_out;
				e_last = cmd_q.last;
				case (cmd_q.op)
					cbse_pkg::OP_BAD: e_kind = cbse_pkg::KIND_BAD;
					cbse_pkg::OP_END: e_kind = cbse_pkg::KIND_END;
					default:          e_byte = cmd_q.data[7:0];
				endcase
			end
			cbse_pkg::BK_TAG: begin
				emit   = can_out;
				fin    = can_out && tag_end;
				e_byte = tag_ch;
				e_last = cmd_q.last && tag_end;
			end
			cbse_pkg::BK_VAL: begin
				if (pos_q == 4'd0 && !is_neg) begin
					adv = 1'b1;
				end else begin
					emit   = can_out;
					adv    = can_out;
					e_byte = val_ch;
					e_last = cmd_q.last && (pos_q == 4'd12);
					fin    = can_out && (pos_q == 4'd12);
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			cbse_pkg::BK_IDLE: begin
				if (pop) begin
					case (rd_data.op)
						cbse_pkg::OP_VAL_COMMA, cbse_pkg::OP_VAL_SPACE: state_n = cbse_pkg::BK_CONV;
						cbse_pkg::OP_OPEN, cbse_pkg::OP_CLOSE:          state_n = cbse_pkg::BK_TAG;
						default:                                        state_n = cbse_pkg::BK_ONE;
					endcase
				end
			end
			cbse_pkg::BK_CONV: begin
				if (conv_cnt_q == 3'd7) state_n = cbse_pkg::BK_VAL;
			end
			cbse_pkg::BK_ONE, cbse_pkg::BK_TAG, cbse_pkg::BK_VAL: begin
				if (fin) state_n = cbse_pkg::BK_IDLE;
			end
			default: state_n = cbse_pkg::BK_IDLE;
		endcase
	end

	// Control registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cbse_pkg::BK_IDLE;
			conv_cnt_q <= 3'd0;
			out_valid  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (pop) conv_cnt_q <= 3'd0;
			else if (state_q == cbse_pkg::BK_CONV) conv_cnt_q <= 3'(conv_cnt_q + 3'd1);
			if (can_out) out_valid <= emit;
		end
	end

	// Command data, conversion and character counters
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q  <= rd_data;
			tpos_q <= 4'd0;
			pos_q  <= 4'd0;
			bcd_q  <= 40'd0;
			mag_q  <= rd_data.data[31] ? 32'(~rd_data.data + 32'd1) : rd_data.data;
		end else begin
			if (state_q == cbse_pkg::BK_CONV) {bcd_q, mag_q} <= dd4;
			if (state_q == cbse_pkg::BK_TAG && emit) tpos_q <= 4'(tpos_q + 4'd1);
			if (state_q == cbse_pkg::BK_VAL && adv)
				pos_q <= (pos_q == 4'd0) ? first_int : 4'(pos_q + 4'd1);
		end
		if (can_out && emit) begin
			out_byte <= e_byte;
			out_kind <= e_kind;
			run_last <= e_last;
		end
	end

`ifndef ASSERT_OFF
	a_conv_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cbse_pkg::BK_VAL) |-> (conv_cnt_q == 3'd0))
		else $error("value printed before conversion finished");
`endif
`ifndef ASSERT_OFF
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_kind != 2'd3))
		else $error("undefined result kind");
`endif

endmodule

// ===== hdl/coord_block_stream_expander_top.sv =====
// Coordinate block stream expander, top level.
// Uses the parser, the command queue and the text generator. Depends on cbse_pkg.
//
// Input channel: in_byte with in_last on the final byte of a file; a transfer happens
// when in_valid is high and in_stall is low. Output channel: one character per transfer
// (out_byte, out_kind, run_last) under out_valid / out_stall.
// The parser takes a byte and then pushes the commands it produces (up to five)
// one per cycle while the queue does not stall; it takes no new byte until the
// last command of the previous one is pushed. The text generator drains the queue
// at one character per cycle while the output does not stall, with a pop step for
// each command; each coordinate value adds a decimal conversion (four bits per
// cycle) before its characters. Apart from while it pushes commands, the parser
// stalls its input only when the queue is full.
// Reset clears all control state; the next byte is taken as the first header byte.
// A stall on the output holds the current character and backs up into the queue
// and then the input. After the last byte of a file the block returns to its reset
// state on its own.
`timescale 1ns / 1ps

module coord_block_stream_expander_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] out_kind,
	output logic       run_last
);

	logic           f_valid, f_stall, b_valid, b_stall;
	cbse_pkg::cmd_t f_data, b_data;

	cbse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_valid  (f_valid),
		.q_stall  (f_stall),
		.q_data   (f_data)
	);

	cbse_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_stall (f_stall),
		.wr_data  (f_data),
		.rd_valid (b_valid),
		.rd_stall (b_stall),
		.rd_data  (b_data)
	);

	cbse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_valid  (b_valid),
		.rd_stall  (b_stall),
		.rd_data   (b_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_kind  (out_kind),
		.run_last  (run_last)
	);

endmodule
